### sv/ngps_pkg.sv
`default_nettype none
package ngps_pkg;
    localparam int Q_W      = 48;   // Q8.40 word
    localparam int V_W      = 47;   // unsigned variance
    localparam int FRAC     = 40;
    localparam int D_W      = 49;   // z - gamma
    localparam int OP_W     = 63;   // multiplier operand / result, signed
    localparam int MAG_W    = 62;   // operand magnitude
    localparam int DIG_W    = 31;   // multiplier digit
    localparam int PROD_W   = 124;  // full magnitude product
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 44;
    localparam int CNT_W    = 11;   // path_count register
    localparam int CFG_IDX_W = 3;
    localparam int MAX_PATHS_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT = 3'd5;
endpackage
`default_nettype wire

### sv/ngps_in_if.sv
`default_nettype none
interface ngps_in_if
    import ngps_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] shock;
    logic [V_W-1:0]        initial_variance;
    logic                  first_day;

    modport source (output valid, shock, initial_variance, first_day, input ready);
    modport sink   (input valid, shock, initial_variance, first_day, output ready);
endinterface
`default_nettype wire

### sv/ngps_out_if.sv
`default_nettype none
interface ngps_out_if
    import ngps_pkg::*;
    #(parameter int PATH_W = 10)
    ();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] excess_return;
    logic [V_W-1:0]        next_variance;
    logic [PATH_W-1:0]     path_index;
    logic                  last_path_of_day;
    logic                  saturated;

    modport source (output valid, excess_return, next_variance, path_index,
                    last_path_of_day, saturated, input ready);
    modport sink   (input valid, excess_return, next_variance, path_index,
                    last_path_of_day, saturated, output ready);
endinterface
`default_nettype wire

### sv/ngps_mem.sv
`default_nettype none
module ngps_mem
    import ngps_pkg::*;
#(
    parameter int DEPTH = MAX_PATHS_DEF,
    parameter int AW    = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire logic [V_W-1:0] i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output logic [V_W-1:0]      o_rdata
);
    logic [V_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### sv/ngps_sqrt.sv
`default_nettype none
module ngps_sqrt
    import ngps_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [V_W-1:0] i_h,
    output logic                o_busy,
    output logic [ROOT_W-1:0]   o_root
);
    localparam int V2_W  = 2 * ROOT_W;   // radicand h * 2^40, padded
    localparam int REM_W = ROOT_W + 3;

    logic [V2_W-1:0]   r_v;
    logic [REM_W-1:0]  r_rem;
    logic [5:0]        r_cnt;
    logic [REM_W-1:0]  rem_s;
    logic [REM_W-1:0]  trial;
    logic              take;

    // one root bit per cycle, restoring
    always_comb begin
        rem_s = {r_rem[REM_W-3:0], r_v[V2_W-1 -: 2]};
        trial = {1'b0, o_root, 2'b01};
        take  = rem_s >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= 6'(ROOT_W - 1);
            r_v    <= V2_W'({i_h, {FRAC{1'b0}}});
            r_rem  <= '0;
            o_root <= '0;
        end else if (o_busy) begin
            r_v    <= {r_v[V2_W-3:0], 2'b00};
            r_rem  <= take ? rem_s - trial : rem_s;
            o_root <= {o_root[ROOT_W-2:0], take};
            r_cnt  <= r_cnt - 6'd1;
            if (r_cnt == '0) begin
                o_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### sv/ngps_mulq.sv
`default_nettype none
module ngps_mulq
    import ngps_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [OP_W-1:0] i_a,
    input  wire logic signed [OP_W-1:0] i_b,
    output logic                        o_done,
    output logic signed [OP_W-1:0]      o_res
);
    localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (FRAC - 1);
    localparam logic [OP_W-1:0] CLAMP = OP_W'(1) << 61;

    logic [MAG_W-1:0]      r_am, r_bm;
    logic                  r_neg;
    logic                  r_busy;
    logic [2:0]            r_ph;
    logic [2*DIG_W-1:0]    r_prod;
    logic [1:0]            r_psh;
    logic [PROD_W-1:0]     r_acc;
    logic [OP_W-1:0]       a_abs, b_abs;
    logic [DIG_W-1:0]      da, db;
    logic [PROD_W-1:0]     addend;
    logic [PROD_W:0]       rnd;
    logic [OP_W-1:0]       mag_res;

    always_comb begin
        a_abs  = i_a[OP_W-1] ? OP_W'(-i_a) : OP_W'(i_a);
        b_abs  = i_b[OP_W-1] ? OP_W'(-i_b) : OP_W'(i_b);
        da     = r_ph[1] ? r_am[MAG_W-1:DIG_W] : r_am[DIG_W-1:0];
        db     = r_ph[0] ? r_bm[MAG_W-1:DIG_W] : r_bm[DIG_W-1:0];
        unique case (r_psh)
            2'd0:    addend = PROD_W'(r_prod);
            2'd1:    addend = PROD_W'(r_prod) << DIG_W;
            default: addend = PROD_W'(r_prod) << (2 * DIG_W);
        endcase
        rnd     = {1'b0, r_acc} + RND;
        mag_res = (|rnd[PROD_W:101]) ? CLAMP : OP_W'(rnd[100:FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
                r_am   <= a_abs[MAG_W-1:0];
                r_bm   <= b_abs[MAG_W-1:0];
                r_neg  <= i_a[OP_W-1] ^ i_b[OP_W-1];
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_ph <= 3'd3) begin
                    r_prod <= (2*DIG_W)'(da) * (2*DIG_W)'(db);
                    r_psh  <= 2'(r_ph[1]) + 2'(r_ph[0]);
                end
                if (r_ph >= 3'd1 && r_ph <= 3'd4) begin
                    r_acc <= r_acc + addend;
                end
                if (r_ph == 3'd5) begin
                    o_res  <= r_neg ? OP_W'(-mag_res) : mag_res;
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_ph <= r_ph + 3'd1;
            end
        end
    end
endmodule
`default_nettype wire

### sv/ngarch_path_simulation_step.sv
// NGARCH(1,1) path step: one shock word in, one result word out.
// Input channel i_item carries shock z, initial variance and the first-day
// flag; output channel o_res carries excess return, next variance, path
// index, end-of-day flag and the saturation flag. The path index comes from
// an internal counter that wraps at the path_count register.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
// high, only while the block is idle.
// For each word the variance store is read first; then the square root runs
// alongside the first four passes through a shared two-digit multiplier and
// holds back the two passes that need sigma; those follow it, and the
// write-back comes last. One word is in flight at a time, so a word is
// accepted only once the last one has gone to the output register; the next
// is accepted while a finished result still sits in the output register.
// A stalled receiver holds the result; the block then waits before write-back.
// Reset (synchronous, active low) clears the counter, the registers
// (path_count to one) and all handshake state; the variance store is not
// cleared and must be seeded with first_day words.
`default_nettype none
module ngarch_path_simulation_step
    import ngps_pkg::*;
#(
    parameter int MAX_PATHS = MAX_PATHS_DEF,
    parameter int PATH_W    = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ngps_in_if.sink                   i_item,
    ngps_out_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [Q_W-1:0]       i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ISSUE, S_WAIT, S_FIN} t_state;

    localparam int PC_W = (PATH_W + 1 > CNT_W) ? PATH_W + 1 : CNT_W;
    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(64'sh8000_0000_0000);

    t_state r_state;

    // configuration
    logic signed [Q_W-1:0] r_lambda, r_omega, r_alpha, r_beta, r_gamma;
    logic [CNT_W-1:0]      r_pcount;

    // per-word working registers
    logic signed [Q_W-1:0] r_z;
    logic [V_W-1:0]        r_init;
    logic                  r_first;
    logic [V_W-1:0]        r_h;
    logic signed [D_W-1:0] r_d;
    logic [PATH_W-1:0]     r_cnt;
    logic                  r_last;
    logic [2:0]            r_op;
    logic signed [OP_W-1:0] r_m [6];

    logic [PC_W-1:0]       eff_count;
    logic                  last_now;
    logic [V_W-1:0]        rd_h;
    logic                  sq_busy;
    logic [ROOT_W-1:0]     sig;
    logic                  mul_start, mul_done;
    logic signed [OP_W-1:0] mul_a, mul_b, mul_res;
    logic signed [SUM_W-1:0] er, nv;
    logic signed [Q_W-1:0] er_sat;
    logic [V_W-1:0]        nv_sat;
    logic                  sat;
    logic                  out_free;
    logic                  accept;

    assign accept        = i_item.valid && i_item.ready;
    assign i_item.ready  = (r_state == S_IDLE);
    assign out_free      = !o_res.valid || o_res.ready;

    // path count clamped to 1 .. MAX_PATHS
    always_comb begin
        if (r_pcount == '0) begin
            eff_count = PC_W'(1);
        end else if (PC_W'(r_pcount) > PC_W'(MAX_PATHS)) begin
            eff_count = PC_W'(MAX_PATHS);
        end else begin
            eff_count = PC_W'(r_pcount);
        end
        last_now = (PC_W'(r_cnt) + PC_W'(1)) >= eff_count;
    end

    ngps_mem #(.DEPTH(MAX_PATHS), .AW(PATH_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FIN && out_free),
        .i_waddr (r_cnt),
        .i_wdata (nv_sat),
        .i_re    (accept),
        .i_raddr (r_cnt),
        .o_rdata (rd_h)
    );

    ngps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_h     (r_first ? r_init : rd_h),
        .o_busy  (sq_busy),
        .o_root  (sig)
    );

    // operand selection for the shared multiplier
    always_comb begin
        mul_start = (r_state == S_ISSUE) && !(r_op >= 3'd4 && sq_busy);
        unique case (r_op)
            3'd0: begin mul_a = OP_W'(r_alpha);  mul_b = OP_W'({1'b0, r_h}); end
            3'd1: begin mul_a = OP_W'(r_beta);   mul_b = OP_W'({1'b0, r_h}); end
            3'd2: begin mul_a = OP_W'(r_d);      mul_b = OP_W'(r_d); end
            3'd3: begin mul_a = r_m[0];          mul_b = r_m[2]; end
            3'd4: begin mul_a = OP_W'(r_lambda); mul_b = OP_W'({1'b0, sig}); end
            default: begin mul_a = OP_W'({1'b0, sig}); mul_b = OP_W'(r_z); end
        endcase
    end

    ngps_mulq u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // final sums and clamps
    always_comb begin
        er  = SUM_W'(r_m[4]) - SUM_W'({1'b0, r_h[V_W-1:1]}) + SUM_W'(r_m[5]);
        nv  = SUM_W'(r_omega) + SUM_W'(r_m[3]) + SUM_W'(r_m[1]);
        sat = 1'b0;
        if (er > Q_MAX) begin
            er_sat = Q_W'(Q_MAX);
            sat    = 1'b1;
        end else if (er < Q_MIN) begin
            er_sat = Q_W'(Q_MIN);
            sat    = 1'b1;
        end else begin
            er_sat = Q_W'(er);
        end
        if (nv < 0) begin
            nv_sat = '0;
            sat    = 1'b1;
        end else if (nv > Q_MAX) begin
            nv_sat = V_W'(Q_MAX);
            sat    = 1'b1;
        end else begin
            nv_sat = V_W'(nv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lambda    <= '0;
            r_omega     <= '0;
            r_alpha     <= '0;
            r_beta      <= '0;
            r_gamma     <= '0;
            r_pcount    <= CNT_W'(1);
            r_cnt       <= '0;
            o_res.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LAMBDA: r_lambda <= i_cfg_data;
                    CFG_OMEGA:  r_omega  <= i_cfg_data;
                    CFG_ALPHA:  r_alpha  <= i_cfg_data;
                    CFG_BETA:   r_beta   <= i_cfg_data;
                    CFG_GAMMA:  r_gamma  <= i_cfg_data;
                    CFG_PCOUNT: r_pcount <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // in S_FIN the valid flag is reloaded below
            if (o_res.valid && o_res.ready && r_state != S_FIN) begin
                o_res.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_z     <= i_item.shock;
                        r_init  <= i_item.initial_variance;
                        r_first <= i_item.first_day;
                        r_last  <= last_now;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_h     <= r_first ? r_init : rd_h;
                    r_d     <= D_W'(r_z) - D_W'(r_gamma);
                    r_op    <= '0;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (mul_start) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_done) begin
                        r_m[r_op] <= mul_res;
                        if (r_op == 3'd5) begin
                            r_state <= S_FIN;
                        end else begin
                            r_op    <= r_op + 3'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_res.valid            <= 1'b1;
                        o_res.excess_return    <= er_sat;
                        o_res.next_variance    <= nv_sat;
                        o_res.path_index       <= r_cnt;
                        o_res.last_path_of_day <= r_last;
                        o_res.saturated        <= sat;
                        r_cnt   <= r_last ? '0 : r_cnt + PATH_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
    import ngps_pkg::*;

    // ---- clock, reset ----
    logic i_clk;
    logic i_rst_n;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---- channels and config port ----
    ngps_in_if                in_ch ();
    ngps_out_if #(.PATH_W(10)) out_ch ();
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [Q_W-1:0]       i_cfg_data;

    ngarch_path_simulation_step u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_res      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ---- word types ----
    typedef struct {
        logic signed [Q_W-1:0] shock;
        logic [V_W-1:0]        init_var;
        logic                  first_day;
    } shock_word_t;

    typedef struct {
        logic [Q_W-1:0] excess;
        logic [V_W-1:0] next_var;
        logic [9:0]     path;
        logic           last;
        logic           sat;
    } path_result_t;

    shock_word_t  shock_q[$];     // words waiting to be sent
    path_result_t result_q[$];    // predicted results, oldest first

    int src_idle_pct;
    int snk_idle_pct;
    int fails;
    int cycle_cnt;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;   // well over the time one word takes
    localparam longint Q_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_LO = -64'sh0000_8000_0000_0000;
    localparam longint ONE_Q = 64'sh0000_0100_0000_0000;  // 1.0 in Q8.40

    // ---- predictor state: own copy of registers and per-path store ----
    longint      lam_r, omega_r, alpha_r, beta_r, gamma_r;
    logic [10:0] npaths_r;
    logic [V_W-1:0] var_mem [1024];
    bit          seeded [1024];   // path variance has been written
    int          path_ctr;

    // Q8.40 product, rounded half away from zero, magnitude clamped to 2^61
    function automatic longint qmul(longint a, longint b);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'b0, ma} * {64'b0, mb};
        p = p + (128'd1 << 39);
        p = p >> FRAC;
        if (p > (128'd1 << 61)) p = 128'd1 << 61;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // floor(sqrt(h * 2^40))
    function automatic longint qsqrt(logic [V_W-1:0] h);
        logic [87:0] v;
        logic [43:0] r;
        logic [43:0] c;
        v = {41'b0, h} << FRAC;
        r = '0;
        for (int b = 43; b >= 0; b--) begin
            c = r | (44'd1 << b);
            if (({44'b0, c} * {44'b0, c}) <= v) r = c;
        end
        return longint'({20'b0, r});
    endfunction

    function automatic void cfg_model(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] d);
        case (idx)
            CFG_LAMBDA: lam_r   = longint'($signed(d));
            CFG_OMEGA:  omega_r = longint'($signed(d));
            CFG_ALPHA:  alpha_r = longint'($signed(d));
            CFG_BETA:   beta_r  = longint'($signed(d));
            CFG_GAMMA:  gamma_r = longint'($signed(d));
            CFG_PCOUNT: npaths_r = d[10:0];
            default: ;
        endcase
    endfunction

    function automatic path_result_t step_path(shock_word_t w);
        path_result_t r;
        longint z, h, sig, er, dz, nv, eff;
        bit sat;
        sat = 1'b0;
        eff = longint'({53'b0, npaths_r});
        if (eff == 0) eff = 1;
        if (eff > 1024) eff = 1024;
        z = longint'(w.shock);
        h = w.first_day ? longint'({17'b0, w.init_var}) : longint'({17'b0, var_mem[path_ctr]});
        sig = qsqrt(h[V_W-1:0]);
        er = qmul(lam_r, sig) - (h >>> 1) + qmul(sig, z);
        if (er > Q_HI) begin er = Q_HI; sat = 1'b1; end
        if (er < Q_LO) begin er = Q_LO; sat = 1'b1; end
        dz = z - gamma_r;
        nv = omega_r + qmul(qmul(alpha_r, h), qmul(dz, dz)) + qmul(beta_r, h);
        if (nv < 0) begin nv = 0; sat = 1'b1; end
        if (nv > Q_HI) begin nv = Q_HI; sat = 1'b1; end
        var_mem[path_ctr] = nv[V_W-1:0];
        seeded[path_ctr] = 1'b1;
        r.excess   = er[Q_W-1:0];
        r.next_var = nv[V_W-1:0];
        r.path     = path_ctr[9:0];
        r.last     = (path_ctr + 1) >= eff;
        r.sat      = sat;
        path_ctr   = r.last ? 0 : path_ctr + 1;
        return r;
    endfunction

    // ---- stimulus helpers ----
    function automatic logic [Q_W-1:0] rnd48();
        return Q_W'({$urandom, $urandom});
    endfunction

    // market-sized coefficients half the time, else full range or its ends
    function automatic logic [Q_W-1:0] rnd_coef();
        case ($urandom_range(0, 5))
            0:       return rnd48();
            1:       return Q_HI[Q_W-1:0];
            2:       return Q_LO[Q_W-1:0];
            default: return 48'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000) <<< 8;
        endcase
    endfunction

    // queue a word and predict its result; first_day forced on unseeded paths
    task automatic push_word(logic signed [Q_W-1:0] z, logic [V_W-1:0] iv, logic fd);
        shock_word_t w;
        w.shock = z;
        w.init_var = iv;
        w.first_day = fd | ~seeded[path_ctr];
        result_q.push_back(step_path(w));
        shock_q.push_back(w);
    endtask

    task automatic push_random_word();
        logic signed [Q_W-1:0] z;
        logic [V_W-1:0] iv;
        if ($urandom_range(0, 9) == 0) z = rnd48();
        else z = 48'($signed($urandom_range(0, 32'hFFFF_FFFF))) <<< 11;  // roughly +-4
        if ($urandom_range(0, 9) == 0) iv = V_W'(rnd48());
        else iv = 47'($urandom_range(0, 32'h0FFF_FFFF)) << 8;
        push_word(z, iv, $urandom_range(0, 9) == 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_model(idx, d);
    endtask

    // block idle: all sent, all results back, pipeline drained
    task automatic wait_idle();
        while (shock_q.size() != 0 || result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---- driver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            bit fire;
            fire = in_ch.valid && in_ch.ready;
            if (fire) void'(shock_q.pop_front());
            if (!in_ch.valid || fire) begin
                if (shock_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    in_ch.valid            <= 1'b1;
                    in_ch.shock            <= shock_q[0].shock;
                    in_ch.initial_variance <= shock_q[0].init_var;
                    in_ch.first_day        <= shock_q[0].first_day;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    path_result_t e;
                    e = result_q.pop_front();
                    if (out_ch.excess_return !== e.excess) begin
                        $error("excess_return exp %h got %h", e.excess, out_ch.excess_return);
                        fails++;
                    end
                    if (out_ch.next_variance !== e.next_var) begin
                        $error("next_variance exp %h got %h", e.next_var, out_ch.next_variance);
                        fails++;
                    end
                    if (out_ch.path_index !== e.path) begin
                        $error("path_index exp %0d got %0d", e.path, out_ch.path_index);
                        fails++;
                    end
                    if (out_ch.last_path_of_day !== e.last) begin
                        $error("last_path_of_day exp %b got %b", e.last,
                               out_ch.last_path_of_day);
                        fails++;
                    end
                    if (out_ch.saturated !== e.sat) begin
                        $error("saturated exp %b got %b", e.sat, out_ch.saturated);
                        fails++;
                    end
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---- sequence ----
    initial begin
        logic [10:0] pc_set [8];
        in_ch.valid = 1'b0;
        in_ch.shock = '0;
        in_ch.initial_variance = '0;
        in_ch.first_day = 1'b0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LAMBDA;
        i_cfg_data = '0;
        fails = 0;
        cycle_cnt = 0;
        src_idle_pct = 21;
        snk_idle_pct = 88;
        lam_r = 0; omega_r = 0; alpha_r = 0; beta_r = 0; gamma_r = 0;
        npaths_r = 11'd1;
        path_ctr = 0;
        foreach (seeded[i]) begin
            seeded[i] = 1'b0;
            var_mem[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers (one path, all zero coefficients)
        push_word(48'sd0, '0, 1'b1);
        push_word(Q_HI[Q_W-1:0], {V_W{1'b1}}, 1'b1);
        wait_idle();

        // directed: typical coefficients, three paths
        cfg_write(CFG_LAMBDA, 48'(ONE_Q / 20));
        cfg_write(CFG_OMEGA,  48'(ONE_Q / 100000));
        cfg_write(CFG_ALPHA,  48'(ONE_Q / 10));
        cfg_write(CFG_BETA,   48'(ONE_Q * 8 / 10));
        cfg_write(CFG_GAMMA,  48'(ONE_Q / 2));
        cfg_write(CFG_PCOUNT, 48'd3);
        push_word(Q_LO[Q_W-1:0], 47'(ONE_Q / 25), 1'b1);
        push_word(Q_HI[Q_W-1:0], {V_W{1'b1}}, 1'b1);   // huge variance, extreme shock
        push_word(48'sd0, '0, 1'b1);                     // zero variance
        push_word(48'(ONE_Q), '0, 1'b0);                 // stored variance follows
        push_word(48'(-ONE_Q), '0, 1'b0);
        push_word(48'(ONE_Q / 2), '0, 1'b0);             // shock equals gamma
        wait_idle();

        // directed: negative variance sum clamps to zero
        cfg_write(CFG_OMEGA, Q_LO[Q_W-1:0]);
        cfg_write(CFG_LAMBDA, Q_HI[Q_W-1:0]);
        push_word(48'(ONE_Q), 47'(ONE_Q), 1'b1);
        push_word(48'(ONE_Q), 47'(ONE_Q), 1'b1);
        push_word(48'(ONE_Q), 47'(ONE_Q), 1'b1);
        wait_idle();

        // directed: path count lowered mid-day, counter sits beyond it
        cfg_write(CFG_OMEGA, 48'(ONE_Q / 100000));
        cfg_write(CFG_LAMBDA, Q_LO[Q_W-1:0]);
        cfg_write(CFG_PCOUNT, 48'd5);
        repeat (3) push_word(48'(ONE_Q / 3), 47'(ONE_Q / 16), 1'b1);
        wait_idle();
        cfg_write(CFG_PCOUNT, 48'd2);
        repeat (2) push_word(48'(-ONE_Q / 3), '0, 1'b0);
        wait_idle();

        // directed: path count zero acts as one, above the maximum as the maximum
        cfg_write(CFG_PCOUNT, 48'd0);
        repeat (2) push_word(48'(ONE_Q), 47'(ONE_Q / 9), 1'b0);
        wait_idle();
        cfg_write(CFG_PCOUNT, 48'd2047);
        repeat (3) push_word(48'(ONE_Q), 47'(ONE_Q / 9), 1'b1);
        wait_idle();

        // random phases: new settings each time, idle regime in three parts
        pc_set = '{11'd1, 11'd4, 11'd17, 11'd1024, 11'd2, 11'd63, 11'd0, 11'd7};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                src_idle_pct = 21; snk_idle_pct = 88;
            end else if (ph < 6) begin
                src_idle_pct = 88; snk_idle_pct = 21;
            end else begin
                src_idle_pct = 0;  snk_idle_pct = 0;
            end
            cfg_write(CFG_LAMBDA, rnd_coef());
            cfg_write(CFG_OMEGA,  rnd_coef());
            cfg_write(CFG_ALPHA,  rnd_coef());
            cfg_write(CFG_BETA,   rnd_coef());
            cfg_write(CFG_GAMMA,  rnd_coef());
            cfg_write(CFG_PCOUNT, {37'b0, pc_set[ph]});
            repeat (94) push_random_word();
            wait_idle();
        end

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
